// ===== hw/rtl/kes_pkg.sv =====
// ----------------------------------------------------------------------------
// kes_pkg
// Shared constants and control/status types for the knapsack exhaustive search
// ----------------------------------------------------------------------------
`default_nettype none

package kes_pkg;

  localparam int MAX_ITEMS  = 16;
  localparam int VALUE_W    = 16;
  localparam int WEIGHT_W   = 16;
  localparam int CAP_W      = 20;
  localparam int TOTAL_W    = 20;
  localparam int CIDX_W     = 4;
  localparam int ITEM_IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CNT_W      = $clog2(MAX_ITEMS + 1);
  localparam int SUM_W      = VALUE_W + ((MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 0);
  localparam int WIDE_W     = (SUM_W > CAP_W) ? SUM_W : CAP_W;

  typedef struct packed {
    logic load;
    logic start;
    logic step;
    logic emit_start;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic last_step;
    logic pipe_busy;
    logic emit_last;
  } sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/kes_if.sv =====
// ----------------------------------------------------------------------------
// kes_if
// Valid/ready channels for item words and result words
// ----------------------------------------------------------------------------
`default_nettype none

interface kes_in_if;
  logic                          valid;
  logic                          ready;
  logic [kes_pkg::VALUE_W-1:0]   item_value;
  logic [kes_pkg::WEIGHT_W-1:0]  item_weight;
  logic                          last_item;

  modport source (output valid, item_value, item_weight, last_item, input ready);
  modport sink   (input valid, item_value, item_weight, last_item, output ready);
endinterface

interface kes_out_if;
  logic                          valid;
  logic                          ready;
  logic [kes_pkg::CIDX_W-1:0]    chosen_index;
  logic [kes_pkg::VALUE_W-1:0]   chosen_value;
  logic [kes_pkg::WEIGHT_W-1:0]  chosen_weight;
  logic [kes_pkg::TOTAL_W-1:0]   best_total;
  logic                          none_chosen;
  logic                          final_result;

  modport source (output valid, chosen_index, chosen_value, chosen_weight, best_total,
                  none_chosen, final_result, input ready);
  modport sink   (input valid, chosen_index, chosen_value, chosen_weight, best_total,
                  none_chosen, final_result, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/kes_ctrl.sv =====
// ----------------------------------------------------------------------------
// kes_ctrl
// Phase sequencer: load, search, pipeline drain and result emission
// ----------------------------------------------------------------------------
`default_nettype none

module kes_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic          in_last,
  output logic               in_ready,
  input  kes_pkg::sts_t      sts,
  output kes_pkg::cmd_t      cmd
);

  typedef enum logic [1:0] {
    S_LOAD,
    S_SEARCH,
    S_DRAIN,
    S_EMIT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    cmd            = '0;
    cmd.load       = (state_r == S_LOAD) && in_valid;
    cmd.start      = cmd.load && in_last;
    cmd.step       = (state_r == S_SEARCH);
    cmd.emit_start = (state_r == S_DRAIN) && !sts.pipe_busy;
    cmd.emit       = (state_r == S_EMIT);
    in_ready       = (state_r == S_LOAD);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_LOAD: begin
        if (cmd.start) state_nxt = S_SEARCH;
      end
      S_SEARCH: begin
        if (sts.last_step) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        if (!sts.pipe_busy) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (sts.emit_last) state_nxt = S_LOAD;
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/kes_dp.sv =====
// ----------------------------------------------------------------------------
// kes_dp
// Item store, gray-order subset accumulator, best tracker and result register
// ----------------------------------------------------------------------------
`default_nettype none

module kes_dp (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  kes_pkg::cmd_t                    cmd,
  output kes_pkg::sts_t                    sts,
  input  wire logic                        cfg_we,
  input  wire logic [kes_pkg::CAP_W-1:0]   cfg_data,
  input  wire logic [kes_pkg::VALUE_W-1:0] in_value,
  input  wire logic [kes_pkg::WEIGHT_W-1:0] in_weight,
  kes_out_if.source                        out_ch
);

  localparam int N   = kes_pkg::MAX_ITEMS;
  localparam int IW  = kes_pkg::ITEM_IDX_W;
  localparam int SW  = kes_pkg::SUM_W;
  localparam int WW  = kes_pkg::WIDE_W;

  function automatic logic [IW-1:0] lowest_set(input logic [N-1:0] m);
    logic [IW-1:0] r;
    r = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (m[i]) r = IW'(i);
    end
    return r;
  endfunction

  function automatic logic [kes_pkg::TOTAL_W-1:0] sat_total(input logic [SW-1:0] s);
    logic [WW-1:0] w;
    logic [WW-1:0] top;
    w   = WW'(s);
    top = WW'({kes_pkg::TOTAL_W{1'b1}});
    if (w > top) return {kes_pkg::TOTAL_W{1'b1}};
    return kes_pkg::TOTAL_W'(w);
  endfunction

  // item store
  logic [kes_pkg::VALUE_W-1:0]  val_mem_r [N];
  logic [kes_pkg::WEIGHT_W-1:0] wt_mem_r  [N];
  logic [kes_pkg::CAP_W-1:0]    cap_r;
  logic [kes_pkg::CNT_W-1:0]    count_r;
  logic [kes_pkg::CNT_W-1:0]    count_nxt;
  logic                         store_ok;

  // subset walk
  logic [N-1:0] k_r;
  logic [N-1:0] lim_r;
  logic [N-1:0] gray_r;
  logic [N-1:0] flip;

  // accumulate pipeline
  logic                          a_valid_r;
  logic                          a_add_r;
  logic [kes_pkg::VALUE_W-1:0]   a_v_r;
  logic [kes_pkg::WEIGHT_W-1:0]  a_w_r;
  logic [N-1:0]                  a_mask_r;
  logic                          b_valid_r;
  logic [SW-1:0]                 b_val_r;
  logic [SW-1:0]                 b_wt_r;
  logic [N-1:0]                  b_mask_r;
  logic [SW-1:0]                 best_val_r;
  logic [N-1:0]                  best_mask_r;
  logic                          fits;
  logic                          better;

  // emission
  logic [N-1:0]                  emit_mask_r;
  logic                          emit_none_r;
  logic [N-1:0]                  emit_rest;
  logic                          push;
  logic                          out_valid_r;
  logic [kes_pkg::CIDX_W-1:0]    o_idx_r;
  logic [kes_pkg::VALUE_W-1:0]   o_val_r;
  logic [kes_pkg::WEIGHT_W-1:0]  o_wt_r;
  logic [kes_pkg::TOTAL_W-1:0]   o_tot_r;
  logic                          o_none_r;
  logic                          o_final_r;

  // shared read port
  logic [IW-1:0]                 step_idx;
  logic [IW-1:0]                 emit_idx;
  logic [IW-1:0]                 rd_idx;
  logic [kes_pkg::VALUE_W-1:0]   rd_v;
  logic [kes_pkg::WEIGHT_W-1:0]  rd_w;

  always_comb begin
    store_ok  = (count_r < kes_pkg::CNT_W'(N));
    count_nxt = store_ok ? count_r + kes_pkg::CNT_W'(1) : count_r;
    step_idx  = lowest_set(k_r);
    emit_idx  = lowest_set(emit_mask_r);
    rd_idx    = cmd.emit ? emit_idx : step_idx;
    rd_v      = val_mem_r[rd_idx];
    rd_w      = wt_mem_r[rd_idx];
    flip      = N'(1) << step_idx;
    emit_rest = emit_mask_r & ~(N'(1) << emit_idx);
    push      = cmd.emit && (!out_valid_r || out_ch.ready);
    fits      = (WW'(b_wt_r) <= WW'(cap_r));
    better    = (b_val_r > best_val_r) ||
                ((b_val_r == best_val_r) && (best_val_r != '0) && (b_mask_r < best_mask_r));

    sts.last_step = (k_r == lim_r);
    sts.pipe_busy = a_valid_r || b_valid_r;
    sts.emit_last = push && (emit_none_r || (emit_rest == '0));
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= '0;
      count_r     <= '0;
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      emit_none_r <= 1'b0;
      emit_mask_r <= '0;
      k_r         <= '0;
      lim_r       <= '0;
    end else begin
      if (cfg_we) cap_r <= cfg_data;
      if (cmd.load) count_r <= count_nxt;
      if (cmd.emit_start) count_r <= '0;

      if (cmd.start) begin
        k_r   <= N'(1);
        lim_r <= ~({N{1'b1}} << count_nxt);
      end else if (cmd.step) begin
        k_r <= k_r + N'(1);
      end

      a_valid_r <= cmd.step;
      b_valid_r <= a_valid_r;

      if (cmd.emit_start) begin
        emit_mask_r <= best_mask_r;
        emit_none_r <= (best_mask_r == '0);
      end else if (push) begin
        emit_none_r <= 1'b0;
        emit_mask_r <= emit_rest;
      end

      if (push) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load && store_ok) begin
      val_mem_r[count_r[IW-1:0]] <= in_value;
      wt_mem_r[count_r[IW-1:0]]  <= in_weight;
    end

    if (cmd.start) begin
      gray_r      <= '0;
      b_val_r     <= '0;
      b_wt_r      <= '0;
      best_val_r  <= '0;
      best_mask_r <= '0;
    end else begin
      if (cmd.step) begin
        gray_r   <= gray_r ^ flip;
        a_add_r  <= !gray_r[step_idx];
        a_v_r    <= rd_v;
        a_w_r    <= rd_w;
        a_mask_r <= gray_r ^ flip;
      end
      if (a_valid_r) begin
        b_val_r  <= a_add_r ? b_val_r + SW'(a_v_r) : b_val_r - SW'(a_v_r);
        b_wt_r   <= a_add_r ? b_wt_r + SW'(a_w_r) : b_wt_r - SW'(a_w_r);
        b_mask_r <= a_mask_r;
      end
      if (b_valid_r && fits && better) begin
        best_val_r  <= b_val_r;
        best_mask_r <= b_mask_r;
      end
    end

    if (push) begin
      if (emit_none_r) begin
        o_idx_r   <= '0;
        o_val_r   <= '0;
        o_wt_r    <= '0;
        o_tot_r   <= '0;
        o_none_r  <= 1'b1;
        o_final_r <= 1'b1;
      end else begin
        o_idx_r   <= kes_pkg::CIDX_W'(emit_idx);
        o_val_r   <= rd_v;
        o_wt_r    <= rd_w;
        o_tot_r   <= sat_total(best_val_r);
        o_none_r  <= 1'b0;
        o_final_r <= (emit_rest == '0);
      end
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.chosen_index  = o_idx_r;
  assign out_ch.chosen_value  = o_val_r;
  assign out_ch.chosen_weight = o_wt_r;
  assign out_ch.best_total    = o_tot_r;
  assign out_ch.none_chosen   = o_none_r;
  assign out_ch.final_result  = o_final_r;

endmodule

`default_nettype wire

// ===== hw/rtl/knapsack_exhaustive_search.sv =====
// ----------------------------------------------------------------------------
// knapsack_exhaustive_search
// 0/1 knapsack solver that tries every subset of up to sixteen loaded items
//
// in_ch carries one item word per handshake (value, weight, last flag); words
// past the sixteenth are dropped but a last flag on them still starts a run.
// cfg_we/cfg_data write the capacity; the user must write it only while the
// block is idle; nothing in the block enforces this. out_ch gives one
// word per chosen item in index order with the best total, final_result on
// the last; a single none_chosen word if nothing is chosen. A run over n
// items walks the 2^n - 1 non-empty subsets in gray order, one subset per
// cycle through a three-stage add and compare pipeline, which then drains
// before emission starts; results leave at one per cycle while out_ch.ready
// is high. in_ch.ready is low from the last item until the final result is
// registered. A stalled receiver holds the output register and pauses
// emission only. Reset clears the capacity and the item count.
// ----------------------------------------------------------------------------
`default_nettype none

module knapsack_exhaustive_search (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  kes_in_if.sink                         in_ch,
  kes_out_if.source                      out_ch,
  input  wire logic                      cfg_we,
  input  wire logic [kes_pkg::CAP_W-1:0] cfg_data
);

  kes_pkg::cmd_t cmd;
  kes_pkg::sts_t sts;

  kes_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_last  (in_ch.last_item),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  kes_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_value  (in_ch.item_value),
    .in_weight (in_ch.item_weight),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

// ===== sim/knapsack_exhaustive_search_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knapsack_exhaustive_search_tb
// Self-checking bench for the exhaustive 0/1 knapsack search. Item words are
// queued and driven, in some phases with random gaps; the best subset is
// worked out here for every set as it is accepted, and each result word is
// checked field by field against it, in some phases with random receiver
// stalls. Capacity only changes between phases, once the block is idle.
// ----------------------------------------------------------------------------
module knapsack_exhaustive_search_tb;
  import kes_pkg::*;

  typedef struct packed {
    logic [VALUE_W-1:0]  value;
    logic [WEIGHT_W-1:0] weight;
    logic                is_last;
  } item_word_t;

  typedef struct packed {
    logic [CIDX_W-1:0]   idx;
    logic [VALUE_W-1:0]  value;
    logic [WEIGHT_W-1:0] weight;
    logic [TOTAL_W-1:0]  total;
    logic                empty;
    logic                tail;
  } pick_word_t;

  typedef enum int {FLOW_FREE, FLOW_SEND_IDLE, FLOW_RECV_STALL, FLOW_BOTH} flow_t;

  localparam int      IDLE_PCT      = 76;
  localparam int      BOTH_PCT      = 13;
  localparam int      HOLD_CYCLES   = 600;
  localparam int      SETTLE_CYCLES = 16;
  localparam int      PHASE_WORDS   = 16;
  localparam int      PHASES        = 6;
  localparam int      REPORT_LIMIT  = 10;
  localparam longint  RUN_LIMIT_NS  = 12_800_000;

  logic             clk      = 1'b0;
  logic             rst_n    = 1'b0;
  logic             cfg_we   = 1'b0;
  logic [CAP_W-1:0] cfg_data = '0;

  kes_in_if  item_ch ();
  kes_out_if pick_ch ();

  knapsack_exhaustive_search dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (item_ch),
    .out_ch   (pick_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always #4 clk = ~clk;

  item_word_t          pending_items[$];
  pick_word_t          expected_picks[$];

  logic [VALUE_W-1:0]  stored_value  [MAX_ITEMS];
  logic [WEIGHT_W-1:0] stored_weight [MAX_ITEMS];
  int unsigned         stored_count   = 0;
  logic [CAP_W-1:0]    capacity_model = '0;

  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  logic hold_on        = 1'b0;
  logic in_took        = 1'b0;

  int mismatches    = 0;
  int picks_checked = 0;
  int sets_solved   = 0;
  int empty_sets    = 0;
  int largest_set   = 0;
  int words_sent    = 0;
  int cap_writes    = 0;

  // store the word; a last flag runs the search in counting order
  function automatic void take_item(input item_word_t w);
    int unsigned        limit, mask, i, best_mask;
    longint unsigned    v_sum, w_sum, best_sum;
    logic [TOTAL_W-1:0] total;
    pick_word_t         r;
    if (stored_count < MAX_ITEMS) begin
      stored_value[stored_count]  = w.value;
      stored_weight[stored_count] = w.weight;
      stored_count++;
    end
    if (!w.is_last) return;
    best_mask = 0;
    best_sum  = 0;
    limit     = 1 << stored_count;
    for (mask = 0; mask < limit; mask++) begin
      v_sum = 0;
      w_sum = 0;
      for (i = 0; i < stored_count; i++) begin
        if ((mask >> i) & 1) begin
          v_sum += stored_value[i];
          w_sum += stored_weight[i];
        end
      end
      if (w_sum <= capacity_model && v_sum > best_sum) begin
        best_mask = mask;
        best_sum  = v_sum;
      end
    end
    total = (best_sum > (2 ** TOTAL_W - 1)) ? '1 : TOTAL_W'(best_sum);
    if (best_mask == 0) begin
      r       = '0;
      r.empty = 1'b1;
      r.tail  = 1'b1;
      expected_picks.push_back(r);
      empty_sets++;
    end else begin
      for (i = 0; i < stored_count; i++) begin
        if ((best_mask >> i) & 1) begin
          r        = '0;
          r.idx    = CIDX_W'(i);
          r.value  = stored_value[i];
          r.weight = stored_weight[i];
          r.total  = total;
          r.tail   = ((best_mask >> (i + 1)) == 0);
          expected_picks.push_back(r);
        end
      end
    end
    if (stored_count > largest_set) largest_set = stored_count;
    sets_solved++;
    stored_count = 0;
  endfunction

  always @(posedge clk) begin : watch
    item_word_t seen;
    pick_word_t got, want;
    in_took = rst_n && item_ch.valid && item_ch.ready;
    if (rst_n && cfg_we) capacity_model = cfg_data;
    if (in_took) begin
      seen.value   = item_ch.item_value;
      seen.weight  = item_ch.item_weight;
      seen.is_last = item_ch.last_item;
      take_item(seen);
    end
    if (rst_n && pick_ch.valid && pick_ch.ready) begin
      got.idx    = pick_ch.chosen_index;
      got.value  = pick_ch.chosen_value;
      got.weight = pick_ch.chosen_weight;
      got.total  = pick_ch.best_total;
      got.empty  = pick_ch.none_chosen;
      got.tail   = pick_ch.final_result;
      picks_checked++;
      if (expected_picks.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: unexpected word idx %0d value %0d weight %0d total %0d empty %b last %b",
                   $time, got.idx, got.value, got.weight, got.total, got.empty, got.tail);
      end else begin
        want = expected_picks.pop_front();
        if (got.idx !== want.idx || got.value !== want.value || got.weight !== want.weight ||
            got.total !== want.total || got.empty !== want.empty || got.tail !== want.tail) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("%0t: expected idx %0d value %0d weight %0d total %0d empty %b last %b",
                     $time, want.idx, want.value, want.weight, want.total, want.empty, want.tail);
            $display("%0t: actual   idx %0d value %0d weight %0d total %0d empty %b last %b",
                     $time, got.idx, got.value, got.weight, got.total, got.empty, got.tail);
          end
        end
      end
    end
  end

  always @(negedge clk) begin : drive_items
    item_word_t next_word;
    logic       next_valid;
    next_valid        = item_ch.valid;
    next_word.value   = item_ch.item_value;
    next_word.weight  = item_ch.item_weight;
    next_word.is_last = item_ch.last_item;
    if (!rst_n) begin
      next_valid = 1'b0;
    end else if (!item_ch.valid || in_took) begin
      next_valid = 1'b0;
      if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_word  = pending_items.pop_front();
        next_valid = 1'b1;
        words_sent++;
      end
    end
    item_ch.valid       <= next_valid;
    item_ch.item_value  <= next_word.value;
    item_ch.item_weight <= next_word.weight;
    item_ch.last_item   <= next_word.is_last;
  end

  always @(negedge clk) begin
    pick_ch.ready <= rst_n && !hold_on && ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic push_word(input int v, input int w, input logic is_last);
    item_word_t word;
    word.value   = VALUE_W'(v);
    word.weight  = WEIGHT_W'(w);
    word.is_last = is_last;
    pending_items.push_back(word);
  endtask

  // extremes turn up often, the rest is uniform
  function automatic int pick_value();
    int roll;
    roll = $urandom_range(9);
    if (roll == 0) return 0;
    if (roll == 1) return 2 ** VALUE_W - 1;
    return $urandom_range(2 ** VALUE_W - 1);
  endfunction

  task automatic push_set(input int n, input int w_hi);
    for (int i = 0; i < n; i++) push_word(pick_value(), $urandom_range(w_hi), i == n - 1);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] c);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= c;
    @(negedge clk);
    cfg_we   <= 1'b0;
    cap_writes++;
  endtask

  task automatic set_flow(input flow_t f);
    case (f)
      FLOW_SEND_IDLE: begin
        send_idle_pct  = IDLE_PCT;
        recv_stall_pct = 0;
      end
      FLOW_RECV_STALL: begin
        send_idle_pct  = 0;
        recv_stall_pct = IDLE_PCT;
      end
      FLOW_BOTH: begin
        send_idle_pct  = BOTH_PCT;
        recv_stall_pct = BOTH_PCT;
      end
      default: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
    endcase
  endtask

  task automatic wait_idle();
    while (pending_items.size() != 0 || item_ch.valid || expected_picks.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [CAP_W-1:0] caps  [PHASES];
    flow_t            flows [PHASES];
    int               phase_words, n, w_hi;
    item_ch.valid       = 1'b0;
    item_ch.item_value  = '0;
    item_ch.item_weight = '0;
    item_ch.last_item   = 1'b0;
    pick_ch.ready       = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_capacity(CAP_W'(100));
    set_flow(FLOW_FREE);
    push_word(2 ** VALUE_W - 1, 0, 1'b1);
    push_word(0, 0, 1'b1);
    push_word(500, 2 ** WEIGHT_W - 1, 1'b1);
    // equal items tie, the lower index wins
    push_word(30, 60, 1'b0);
    push_word(30, 60, 1'b0);
    push_word(0, 0, 1'b1);
    // full store, the last flag rides on a dropped word
    for (int i = 0; i <= MAX_ITEMS; i++) push_word(pick_value(), $urandom_range(40), i == MAX_ITEMS);
    wait_idle();

    caps  = '{'0, '1, CAP_W'($urandom_range(2000)), CAP_W'($urandom),
              CAP_W'($urandom_range(100, 5000)), CAP_W'(1)};
    flows = '{FLOW_SEND_IDLE, FLOW_RECV_STALL, FLOW_BOTH, FLOW_FREE, FLOW_BOTH, FLOW_FREE};
    for (int p = 0; p < PHASES; p++) begin
      write_capacity(caps[p]);
      set_flow(flows[p]);
      if (p == 3) begin
        fork
          begin
            @(posedge clk);
            hold_on = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_on = 1'b0;
          end
        join_none
      end
      // every item fits under the largest capacity, so all sixteen come back
      if (p == 1)
        for (int i = 0; i < MAX_ITEMS; i++)
          push_word($urandom_range(1, 2 ** VALUE_W - 1), $urandom_range(2 ** WEIGHT_W - 1),
                    i == MAX_ITEMS - 1);
      phase_words = 0;
      while (phase_words < PHASE_WORDS) begin
        n = ($urandom_range(7) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
        case ($urandom_range(2))
          0:       w_hi = 255;
          1:       w_hi = 4095;
          default: w_hi = 2 ** WEIGHT_W - 1;
        endcase
        push_set(n, w_hi);
        phase_words += n;
      end
      wait_idle();
    end

    $display("covered %0d item words in %0d sets over %0d capacity settings, largest set %0d",
             words_sent, sets_solved, cap_writes, largest_set);
    $display("checked %0d result words, %0d sets with nothing chosen, %0d mismatches",
             picks_checked, empty_sets, mismatches);
    if (mismatches == 0 && expected_picks.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("timeout with %0d result words outstanding", expected_picks.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/kes_pkg.sv
hw/rtl/kes_if.sv
hw/rtl/kes_ctrl.sv
hw/rtl/kes_dp.sv
hw/rtl/knapsack_exhaustive_search.sv
sim/knapsack_exhaustive_search_tb.sv
